// ===== sv/splc_pkg.sv =====
// Shared types and constants for the phosphorus leaching column.
`timescale 1ns / 1ps
`default_nettype none
package splc_pkg;

  localparam int unsigned W = 32;
  localparam int unsigned DW = 48;
  localparam logic [DW-1:0] MAX48 = {DW{1'b1}};

  localparam logic CFG_PARTITION = 1'b0;
  localparam logic CFG_PERC = 1'b1;

  // Multiplier operand select.
  typedef enum logic [2:0] {
    MS_BD_DEPTH, MS_AB_PART, MS_BD_THICK, MS_AB_PERC,
    MS_SOLP_RUNOFF, MS_SOLP_PERCO, MS_VAP_FRAC
  } msel_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic  load;
    logic  mul_go;
    logic  mul_hi;
    msel_t msel;
    logic  save_xx;
    logic  save_ld;
    logic  div_go;
    logic  fin_surq;
    logic  fin_vap;
    logic  fin_tile;
    logic  out_load;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_done;
    logic first;
    logic tile;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/splc_div.sv =====
// Restoring serial divider: 64-bit dividend by 48-bit divisor, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module splc_div
  import splc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          go,
  input  wire logic [63:0]   dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [63:0]        quotient
);

  logic [63:0]   q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem_r, q_r[63]};
  assign diff = trial - {1'b0, d_r};

  // Shift one dividend bit into the remainder and subtract when it fits.
  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go) begin
      q_nxt = dividend;
      rem_nxt = '0;
      d_nxt = divisor;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (d_r == '0) begin
        q_nxt = '1;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (trial >= {1'b0, d_r}) begin
          rem_nxt = diff[DW-1:0];
          q_nxt = {q_r[62:0], 1'b1};
        end else begin
          rem_nxt = trial[DW-1:0];
          q_nxt = {q_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

// ===== sv/splc_dp.sv =====
// Datapath: layer registers, shared multiplier, divider and result register.
`timescale 1ns / 1ps
`default_nettype none
module splc_dp
  import splc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cmd_t         cmd,
  output sts_t              sts,
  input  wire logic         cfg_we,
  input  wire logic         cfg_idx,
  input  wire logic [W-1:0] cfg_wdata,
  input  wire logic         in_first_layer,
  input  wire logic         in_last_layer,
  input  wire logic [W-1:0] in_layer_solp,
  input  wire logic [W-1:0] in_layer_perco,
  input  wire logic [W-1:0] in_bulk_density,
  input  wire logic [W-1:0] in_top_thickness,
  input  wire logic [W-1:0] in_top_depth,
  input  wire logic [W-1:0] in_surface_runoff,
  input  wire logic [W-1:0] in_crack_volume,
  input  wire logic         in_has_tile_drain,
  output logic [W-1:0]      out_new_solp,
  output logic [W-1:0]      out_runoff_p,
  output logic [W-1:0]      out_groundwater_p,
  output logic              out_cell_done
);

  localparam logic [W:0] ONE = (W+1)'(1) << FRAC_BITS;
  localparam logic [W-1:0] PART_RST = 32'd175 << FRAC_BITS;
  localparam logic [W-1:0] PERC_RST = 32'd10 << FRAC_BITS;
  // Reciprocals: x/5 = (x*DIV5_MUL)>>34 and x/3 = (x*DIV3_MUL)>>33 for 32-bit x.
  localparam logic [W-1:0] DIV5_MUL = 32'hCCCC_CCCD;
  localparam logic [W-1:0] DIV3_MUL = 32'hAAAA_AAAB;

  logic [W-1:0] part_r, perc_r;
  logic [W-1:0] carry_r, carry_nxt;
  logic [DW-1:0] ld_r;
  logic [DW-1:0] xx_r;
  logic first_r, last_r, tile_r;
  logic [W-1:0] solp_r, perco_r, bd_r, thick_r, depth_r, runoff_r, crack_r;
  logic [W-1:0] surq_r, vap_r;
  logic [63:0] ab_r, prod_r;
  logic [95:0] wide_r;
  logic [W-1:0] ma, mb;
  logic [63:0] prod;
  logic [DW-1:0] sat3;
  logic [DW-1:0] ld10;
  logic [DW-1:0] dvs;
  logic div_done;
  logic [63:0] quo;
  logic [W-1:0] cap_r, frac_r;
  logic [63:0] m5, m3;
  logic [W:0] solp_sum;
  logic [W:0] frac_raw;

  // Write configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= PART_RST;
      perc_r <= PERC_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PARTITION: part_r <= cfg_wdata;
        CFG_PERC:      perc_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Select multiplier operands; ab is multiplied in two 32-bit halves.
  always_comb begin
    unique case (cmd.msel)
      MS_BD_DEPTH:    begin ma = bd_r;    mb = depth_r; end
      MS_AB_PART:     begin ma = cmd.mul_hi ? ab_r[63:32] : ab_r[31:0]; mb = part_r; end
      MS_BD_THICK:    begin ma = bd_r;    mb = thick_r; end
      MS_AB_PERC:     begin ma = cmd.mul_hi ? ab_r[63:32] : ab_r[31:0]; mb = perc_r; end
      MS_SOLP_RUNOFF: begin ma = solp_r;  mb = runoff_r; end
      MS_SOLP_PERCO:  begin ma = solp_r;  mb = perco_r; end
      MS_VAP_FRAC:    begin ma = vap_r;   mb = frac_r; end
      default:        begin ma = '0;      mb = '0; end
    endcase
  end

  // 32x32 core.
  assign prod = {32'd0, ma} * {32'd0, mb};

  // Saturate the triple product: ab*c >> F, clamp to 48 bits.
  always_comb begin
    logic [95:0] sh;
    sh = wide_r >> FRAC_BITS;
    sat3 = (sh > 96'(MAX48)) ? MAX48 : sh[DW-1:0];
  end
  always_comb begin
    logic [51:0] t;
    t = 52'(sat3) * 52'd10;
    ld10 = (sat3 > MAX48 / 10) ? MAX48 : t[DW-1:0];
  end

  // Hold products; the high half of ab*c accumulates in the cycle after the low half.
  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod_r <= prod;
      wide_r <= {32'd0, prod};
      if (cmd.msel == MS_BD_DEPTH || cmd.msel == MS_BD_THICK) ab_r <= prod >> FRAC_BITS;
    end else if (cmd.mul_hi) begin
      wide_r <= wide_r + {prod, 32'd0};
    end
  end

  assign dvs = (cmd.msel == MS_SOLP_RUNOFF) ? xx_r : ld_r;

  splc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (prod_r),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  // Precompute the leach cap and crack fraction; their inputs hold through the divide.
  assign m5 = {32'd0, solp_r} * {32'd0, DIV5_MUL};
  assign m3 = {32'd0, crack_r} * {32'd0, DIV3_MUL};
  assign frac_raw = {2'b00, m3[63:33]};
  always_ff @(posedge clk) begin
    cap_r <= first_r ? {1'b0, solp_r[W-1:1]} : {2'b00, m5[63:34]};
    frac_r <= (frac_raw > ONE) ? W'(ONE) : frac_raw[W-1:0];
  end

  assign solp_sum = {1'b0, in_layer_solp} + {1'b0, carry_r};

  // Hold layer fields, state and intermediate results.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r <= in_first_layer;
      last_r <= in_last_layer;
      tile_r <= in_has_tile_drain;
      solp_r <= in_first_layer ? in_layer_solp
              : (solp_sum[W] ? '1 : solp_sum[W-1:0]);
      perco_r <= in_layer_perco;
      bd_r <= in_bulk_density;
      thick_r <= in_top_thickness;
      depth_r <= in_top_depth;
      runoff_r <= in_surface_runoff;
      crack_r <= in_crack_volume;
      surq_r <= '0;
    end
    if (cmd.save_xx) xx_r <= sat3;
    if (cmd.fin_surq) begin
      surq_r <= (quo < 64'(solp_r)) ? quo[W-1:0] : solp_r;
      solp_r <= solp_r - ((quo < 64'(solp_r)) ? quo[W-1:0] : solp_r);
    end
    if (cmd.fin_vap) begin
      vap_r <= (quo < 64'(cap_r)) ? quo[W-1:0] : cap_r;
      solp_r <= solp_r - ((quo < 64'(cap_r)) ? quo[W-1:0] : cap_r);
    end
    if (cmd.fin_tile) vap_r <= vap_r - prod[W+FRAC_BITS-1:FRAC_BITS];
    if (cmd.out_load) begin
      out_new_solp <= solp_r;
      out_runoff_p <= surq_r;
      out_groundwater_p <= (last_r && !first_r) ? vap_r : '0;
      out_cell_done <= last_r;
    end
  end

  // Carried phosphorus and leach divisor state.
  always_comb begin
    carry_nxt = carry_r;
    if (cmd.out_load) carry_nxt = last_r ? '0 : vap_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
      ld_r <= '0;
    end else begin
      carry_r <= carry_nxt;
      if (cmd.save_ld) ld_r <= ld10;
    end
  end

  assign sts = '{div_done: div_done, first: first_r, tile: tile_r};

endmodule
`default_nettype wire

// ===== sv/splc_ctrl.sv =====
// Controller: sequences multiplies and divides for one layer.
`timescale 1ns / 1ps
`default_nettype none
module splc_ctrl
  import splc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_M1    = 15'b000000000000010,
    S_M2    = 15'b000000000000100,
    S_M2H   = 15'b000000000001000,
    S_M3    = 15'b000000000010000,
    S_M4    = 15'b000000000100000,
    S_M4H   = 15'b000000001000000,
    S_SAVE  = 15'b000000010000000,
    S_RMUL  = 15'b000000100000000,
    S_RDIV  = 15'b000001000000000,
    S_LMUL  = 15'b000010000000000,
    S_LDIV  = 15'b000100000000000,
    S_LWAIT = 15'b001000000000000,
    S_TILE  = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic ovalid_r, ovalid_nxt;
  logic rwait_r, rwait_nxt;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ovalid_r;

  // Step through the layer sequence.
  always_comb begin
    state_nxt = state_r;
    ovalid_nxt = ovalid_r && out_stall;
    rwait_nxt = rwait_r;
    cmd = '0;
    cmd.msel = MS_SOLP_PERCO;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_M1;
        end
      end
      S_M1: begin
        if (sts.first) begin
          cmd.msel = MS_BD_DEPTH; cmd.mul_go = 1'b1; state_nxt = S_M2;
        end else begin
          state_nxt = S_LMUL;
        end
      end
      S_M2: begin cmd.msel = MS_AB_PART; cmd.mul_go = 1'b1; state_nxt = S_M2H; end
      S_M2H: begin cmd.msel = MS_AB_PART; cmd.mul_hi = 1'b1; state_nxt = S_M3; end
      S_M3: begin
        cmd.save_xx = 1'b1;
        cmd.msel = MS_BD_THICK; cmd.mul_go = 1'b1; state_nxt = S_M4;
      end
      S_M4: begin cmd.msel = MS_AB_PERC; cmd.mul_go = 1'b1; state_nxt = S_M4H; end
      S_M4H: begin cmd.msel = MS_AB_PERC; cmd.mul_hi = 1'b1; state_nxt = S_SAVE; end
      S_SAVE: begin cmd.save_ld = 1'b1; state_nxt = S_RMUL; end
      S_RMUL: begin
        cmd.msel = MS_SOLP_RUNOFF; cmd.mul_go = 1'b1; state_nxt = S_RDIV;
        rwait_nxt = 1'b0;
      end
      S_RDIV: begin
        cmd.msel = MS_SOLP_RUNOFF;
        if (!rwait_r) begin
          cmd.div_go = 1'b1; rwait_nxt = 1'b1;
        end else if (sts.div_done) begin
          cmd.fin_surq = 1'b1; state_nxt = S_LMUL;
        end
      end
      S_LMUL: begin cmd.mul_go = 1'b1; state_nxt = S_LDIV; end
      S_LDIV: begin cmd.div_go = 1'b1; state_nxt = S_LWAIT; end
      S_LWAIT: begin
        if (sts.div_done) begin
          cmd.fin_vap = 1'b1;
          state_nxt = (sts.first && sts.tile) ? S_TILE : S_OUT;
        end
      end
      S_TILE: begin cmd.msel = MS_VAP_FRAC; cmd.fin_tile = 1'b1; state_nxt = S_OUT; end
      S_OUT: begin
        if (!ovalid_r || !out_stall) begin
          cmd.out_load = 1'b1; ovalid_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
      rwait_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
      rwait_r <= rwait_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/soil_phosphorus_leaching_column.sv =====
// Top level of the soluble phosphorus runoff and leaching column.
// Result timing is set by the 64-step serial divider: two divides on a top layer,
//   one on a lower layer, and a top layer with a tile drain also takes the tile step.
// One layer transaction at a time; a new layer is accepted once the last has reached
//   the output register, which lets the next layer start while a result waits.
// Synchronous active-low reset clears carry, leach divisor and coefficients to defaults.
`timescale 1ns / 1ps
`default_nettype none
module soil_phosphorus_leaching_column
  import splc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_idx,
  input  wire logic [W-1:0] cfg_wdata,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic         in_first_layer,
  input  wire logic         in_last_layer,
  input  wire logic [W-1:0] in_layer_solp,
  input  wire logic [W-1:0] in_layer_perco,
  input  wire logic [W-1:0] in_bulk_density,
  input  wire logic [W-1:0] in_top_thickness,
  input  wire logic [W-1:0] in_top_depth,
  input  wire logic [W-1:0] in_surface_runoff,
  input  wire logic [W-1:0] in_crack_volume,
  input  wire logic         in_has_tile_drain,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [W-1:0]      out_new_solp,
  output logic [W-1:0]      out_runoff_p,
  output logic [W-1:0]      out_groundwater_p,
  output logic              out_cell_done
);

  cmd_t cmd;
  sts_t sts;

  splc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  splc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx[0]), .cfg_wdata(cfg_wdata),
    .in_first_layer(in_first_layer), .in_last_layer(in_last_layer),
    .in_layer_solp(in_layer_solp), .in_layer_perco(in_layer_perco),
    .in_bulk_density(in_bulk_density), .in_top_thickness(in_top_thickness),
    .in_top_depth(in_top_depth), .in_surface_runoff(in_surface_runoff),
    .in_crack_volume(in_crack_volume), .in_has_tile_drain(in_has_tile_drain),
    .out_new_solp(out_new_solp), .out_runoff_p(out_runoff_p),
    .out_groundwater_p(out_groundwater_p), .out_cell_done(out_cell_done)
  );

endmodule
`default_nettype wire

// ===== bench/splc_checker.sv =====
// Result checker for the phosphorus leaching column: predicts and compares.
`timescale 1ns / 1ps
module splc_checker
  import splc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_idx,
  input  logic [W-1:0] cfg_wdata,
  input  logic         in_valid,
  input  logic         in_stall,
  input  logic         in_first_layer,
  input  logic         in_last_layer,
  input  logic [W-1:0] in_layer_solp,
  input  logic [W-1:0] in_layer_perco,
  input  logic [W-1:0] in_bulk_density,
  input  logic [W-1:0] in_top_thickness,
  input  logic [W-1:0] in_top_depth,
  input  logic [W-1:0] in_surface_runoff,
  input  logic [W-1:0] in_crack_volume,
  input  logic         in_has_tile_drain,
  input  logic         out_valid,
  input  logic         out_stall,
  input  logic [W-1:0] out_new_solp,
  input  logic [W-1:0] out_runoff_p,
  input  logic [W-1:0] out_groundwater_p,
  input  logic         out_cell_done,
  output int           fail_count,
  output int           pending_layers,
  output int           layers_checked
);

  localparam int F = 16;

  typedef struct packed {
    logic [W-1:0] solp;
    logic [W-1:0] runoff;
    logic [W-1:0] gw;
    logic         done;
  } layer_res_t;

  layer_res_t   expected_layers[$];
  logic [W-1:0] partition_q, perc_q, carried_p;
  logic [63:0]  leach_div;

  // Saturating triple product in Q16.16.
  function automatic logic [63:0] prod3(logic [63:0] a, logic [63:0] b, logic [63:0] c);
    logic [63:0]  ab;
    logic [127:0] m;
    ab = (a * b) >> F;
    m = ({64'd0, ab} * {64'd0, c}) >> F;
    if (m > {80'd0, MAX48}) return {16'd0, MAX48};
    return m[63:0];
  endfunction

  // Truncated quotient; zero divisor saturates.
  function automatic logic [63:0] ratio(logic [63:0] x, logic [63:0] y, logic [63:0] d);
    if (d == 0) return '1;
    return (x * y) / d;
  endfunction

  // Advance the column model by one layer.
  function automatic layer_res_t leach_layer(logic first, logic last,
      logic [63:0] solp, logic [63:0] perco, logic [63:0] bd, logic [63:0] thick,
      logic [63:0] depth, logic [63:0] runoff, logic [63:0] crack, logic tile);
    layer_res_t  r;
    logic [63:0] xx, d, q, cap, vap, frac, surq, gw;
    surq = 0;
    gw = 0;
    if (first) begin
      xx = prod3(bd, depth, partition_q);
      d = prod3(bd, thick, perc_q);
      leach_div = (d > MAX48 / 10) ? {16'd0, MAX48} : d * 10;
      q = ratio(solp, runoff, xx);
      surq = (q < solp) ? q : solp;
      solp -= surq;
      q = ratio(solp, perco, leach_div);
      cap = solp >> 1;
      vap = (q < cap) ? q : cap;
      solp -= vap;
      if (tile) begin
        frac = crack / 3;
        if (frac > (64'd1 << F)) frac = 64'd1 << F;
        vap -= (vap * frac) >> F;
      end
      carried_p = last ? '0 : vap[W-1:0];
    end else begin
      solp += carried_p;
      if (solp > 64'hFFFF_FFFF) solp = 64'hFFFF_FFFF;
      q = ratio(solp, perco, leach_div);
      cap = solp / 5;
      vap = (q < cap) ? q : cap;
      solp -= vap;
      if (last) begin
        gw = vap;
        carried_p = '0;
      end else begin
        carried_p = vap[W-1:0];
      end
    end
    r.solp = solp[W-1:0];
    r.runoff = surq[W-1:0];
    r.gw = gw[W-1:0];
    r.done = last;
    return r;
  endfunction

  assign pending_layers = expected_layers.size();

  // Track config, predict on input transactions, compare on output transactions.
  always @(posedge clk) begin
    layer_res_t e;
    if (!rst_n) begin
      partition_q <= 32'd11468800;
      perc_q <= 32'd655360;
      carried_p = '0;
      leach_div = '0;
      fail_count <= 0;
      layers_checked <= 0;
      expected_layers.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_PARTITION) partition_q <= cfg_wdata;
        else partition_q <= partition_q;
        if (cfg_idx == CFG_PERC) perc_q <= cfg_wdata;
      end
      if (in_valid && !in_stall)
        expected_layers.push_back(leach_layer(in_first_layer, in_last_layer,
            in_layer_solp, in_layer_perco, in_bulk_density, in_top_thickness,
            in_top_depth, in_surface_runoff, in_crack_volume, in_has_tile_drain));
      if (out_valid && !out_stall) begin
        layers_checked <= layers_checked + 1;
        if (expected_layers.size() == 0) begin
          $display("%0t: unexpected result solp=%h", $realtime, out_new_solp);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_layers.pop_front();
          if (e.solp !== out_new_solp || e.runoff !== out_runoff_p ||
              e.gw !== out_groundwater_p || e.done !== out_cell_done) begin
            $display("%0t: mismatch expected solp=%h runoff=%h gw=%h done=%b",
                     $realtime, e.solp, e.runoff, e.gw, e.done);
            $display("%0t:          actual solp=%h runoff=%h gw=%h done=%b",
                     $realtime, out_new_solp, out_runoff_p, out_groundwater_p,
                     out_cell_done);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
// Stimulus and verdict for the phosphorus leaching column.
`timescale 1ns / 1ps
module tb;
  import splc_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 200;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_idx = CFG_PARTITION;
  logic [W-1:0] cfg_wdata = '0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic         in_first_layer = 1'b0, in_last_layer = 1'b0, in_has_tile_drain = 1'b0;
  logic [W-1:0] in_layer_solp = '0, in_layer_perco = '0, in_bulk_density = '0;
  logic [W-1:0] in_top_thickness = '0, in_top_depth = '0, in_surface_runoff = '0;
  logic [W-1:0] in_crack_volume = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [W-1:0] out_new_solp, out_runoff_p, out_groundwater_p;
  logic         out_cell_done;
  int           fail_count, pending_layers, layers_checked;
  int           send_idle_pct = 0, recv_idle_pct = 0;
  int           hold_off = 0;
  int           quiet_cycles = 0;
  int           layers_sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  soil_phosphorus_leaching_column u_top (.*);

  splc_checker u_chk (.*);

  // Drive the receiver stall at the falling edge; a long hold-off wins.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", IDLE_LIMIT);
      $display("[soil_phosphorus_leaching_column] ERROR");
      $finish;
    end
  end

  function automatic logic [W-1:0] rand_q();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(32'h0010_0000);
      3: return $urandom_range(32'h0400_0000);
      default: return $urandom;
    endcase
  endfunction

  // Offer one layer and hold it until accepted.
  task automatic send_layer(logic first, logic last, logic [W-1:0] solp,
      logic [W-1:0] perco, logic [W-1:0] bd, logic [W-1:0] thick,
      logic [W-1:0] depth, logic [W-1:0] runoff, logic [W-1:0] crack, logic tile);
    do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    in_valid <= 1'b1;
    in_first_layer <= first;
    in_last_layer <= last;
    in_layer_solp <= solp;
    in_layer_perco <= perco;
    in_bulk_density <= bd;
    in_top_thickness <= thick;
    in_top_depth <= depth;
    in_surface_runoff <= runoff;
    in_crack_volume <= crack;
    in_has_tile_drain <= tile;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid <= 1'b0;
    layers_sent++;
  endtask

  task automatic send_random_layer(logic first, logic last);
    send_layer(first, last, rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
               rand_q(), rand_q(), 1'($urandom_range(1)));
  endtask

  // Random cell of one to six layers; some broken sequences mixed in.
  task automatic send_cell();
    int n;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(19) == 0)
        send_random_layer(1'($urandom_range(1)), 1'($urandom_range(1)));
      else send_random_layer(k == 0, k == n - 1);
    end
  endtask

  // Drain all results, then let the block settle.
  task automatic drain();
    while (pending_layers != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: lower layer straight after reset, zero divisors, extremes.
    send_layer(0, 0, 32'h0010_0000, 32'h0001_0000, 0, 0, 0, 0, 0, 0);
    send_layer(0, 1, '1, '1, '1, '1, '1, '1, '1, 1);
    send_layer(1, 1, 32'h0064_0000, 32'h0032_0000, 32'h0001_8000, 32'h000A_0000,
               32'h000A_0000, 32'h0005_0000, 32'h0001_0000, 1);
    send_layer(1, 0, '1, '1, 0, 0, 0, '1, '1, 1);
    send_layer(0, 0, '1, 0, '1, '1, '1, '1, '1, 0);
    send_layer(0, 1, '1, '1, 0, 0, 0, 0, 0, 0);
    send_layer(1, 0, 32'h00C8_0000, 32'h0100_0000, '1, '1, '1, 32'h0001_0000,
               32'h0002_0000, 1);
    send_layer(0, 0, 32'h0001_0000, 32'h0010_0000, 0, 0, 0, 0, 0, 0);
    send_layer(1, 0, 32'h0001_0000, 32'h0010_0000, 32'h0001_0000, 32'h0001_0000,
               32'h0001_0000, 32'h0001_0000, 32'h0009_0000, 1);
    send_layer(0, 1, 32'h0001_0000, 32'h0010_0000, 0, 0, 0, 0, 0, 0);
    send_layer(1, 0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
               32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0);
    send_layer(0, 1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
               32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1);
    drain();

    // Sender idles 37%, receiver 49%; walk through coefficient settings.
    send_idle_pct = 37;
    recv_idle_pct = 49;
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: begin write_reg(CFG_PARTITION, 32'd1); write_reg(CFG_PERC, '1); end
        1: begin write_reg(CFG_PARTITION, '1); write_reg(CFG_PERC, 32'd1); end
        2: begin write_reg(CFG_PARTITION, 32'h0001_0000); write_reg(CFG_PERC, 32'h0000_8000); end
        default: begin write_reg(CFG_PARTITION, 32'd11468800); write_reg(CFG_PERC, 32'd655360); end
      endcase
      while (layers_sent < 12 + (s + 1) * 90) send_cell();
      drain();
    end

    // Long receiver hold-off while items keep coming, so the input stalls.
    hold_off = 400;
    repeat (6) send_cell();
    drain();

    // Receiver idles 37%, sender 49%.
    send_idle_pct = 49;
    recv_idle_pct = 37;
    write_reg(CFG_PARTITION, $urandom_range(1, 32'h0100_0000));
    write_reg(CFG_PERC, $urandom_range(1, 32'h0100_0000));
    while (layers_sent < 750) send_cell();
    drain();

    // No idling at all.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_PARTITION, $urandom);
    write_reg(CFG_PERC, $urandom);
    while (layers_sent < 1110) send_cell();
    drain();

    $display("Covered %0d layer transactions, %0d results checked, across seven",
             layers_sent, layers_checked);
    $display("coefficient settings with random idling and a long output hold-off.");
    if (fail_count == 0 && pending_layers == 0) begin
      $display("[soil_phosphorus_leaching_column] OK");
    end else begin
      $display("[soil_phosphorus_leaching_column] ERROR");
    end
    $finish;
  end

endmodule
